// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define WVBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define WVBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/wvbd_pkg.sv -----
// ----------------------------------------------------------------------------
// wvbd_pkg
// Types and constants shared by the vibration burst detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wvbd_pkg;

    // Register file geometry.
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;

    // Register reset values.
    localparam logic [7:0]  THRESHOLD_RST = 8'd1;
    localparam logic [15:0] WINDOW_RST    = 16'd300;
    localparam logic [15:0] HOLD_RST      = 16'd1000;

    // Saturation limit of the edge counter.
    localparam logic [7:0] COUNT_MAX = 8'd255;

    // Detector phases.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_HOLD  = 2'd2
    } t_phase;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [7:0]  threshold;
        logic [15:0] window_ticks;
        logic [15:0] hold_ticks;
    } t_cfg;

    // One result word.
    typedef struct packed {
        logic       detected;
        logic       window_closed;
        logic [7:0] burst_count;
        logic       busy_res;
    } t_result;

endpackage

// ----- src/wvbd_if.sv -----
// ----------------------------------------------------------------------------
// wvbd channel interfaces
// Valid/ready channels for pin samples in and detector results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Input channel: one pin sample per word.
interface wvbd_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

// Output channel: one detector result per word.
interface wvbd_out_if;
    logic       valid;
    logic       ready;
    logic       detected;
    logic       window_closed;
    logic [7:0] burst_count;
    logic       busy_res;

    modport source (output valid, output detected, output window_closed,
                    output burst_count, output busy_res, input ready);
    modport sink   (input valid, input detected, input window_closed,
                    input burst_count, input busy_res, output ready);
endinterface

// ----- src/wvbd_cfg.sv -----
// ----------------------------------------------------------------------------
// wvbd_cfg
// APB register file holding threshold, window length and hold length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wvbd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wvbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [wvbd_pkg::DATA_W-1:0]  pwdata,
    output logic [wvbd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output wvbd_pkg::t_cfg               o_cfg
);

    logic [1:0] w_index;
    logic       w_write;

    wvbd_pkg::t_cfg r_cfg;

    assign w_index = paddr[3:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes on the access cycle; other indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= wvbd_pkg::THRESHOLD_RST;
            r_cfg.window_ticks <= wvbd_pkg::WINDOW_RST;
            r_cfg.hold_ticks   <= wvbd_pkg::HOLD_RST;
        end else if (w_write) begin
            case (w_index)
                wvbd_pkg::REG_THRESHOLD: r_cfg.threshold    <= pwdata[7:0];
                wvbd_pkg::REG_WINDOW:    r_cfg.window_ticks <= pwdata[15:0];
                wvbd_pkg::REG_HOLD:      r_cfg.hold_ticks   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (w_index)
            wvbd_pkg::REG_THRESHOLD: prdata = {24'd0, r_cfg.threshold};
            wvbd_pkg::REG_WINDOW:    prdata = {16'd0, r_cfg.window_ticks};
            wvbd_pkg::REG_HOLD:      prdata = {16'd0, r_cfg.hold_ticks};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ----- src/wvbd_core.sv -----
// ----------------------------------------------------------------------------
// wvbd_core
// Edge detector, window and hold counters, and the burst compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wvbd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_pin_level,
    input  wvbd_pkg::t_cfg      i_cfg,
    output wvbd_pkg::t_result   o_result
);

    wvbd_pkg::t_phase r_phase, n_phase;
    logic             r_prev_level;
    logic [15:0]      r_tick, n_tick;
    logic [7:0]       r_count, n_count;
    logic             r_detect, n_detect;

    logic             w_edge;
    logic [15:0]      w_tick_inc;
    logic [9:0]       w_count_x2;
    logic [9:0]       w_thresh_x3;
    logic             w_strobe;

    // Falling edge of the sensor pin.
    assign w_edge     = r_prev_level & ~i_pin_level;
    assign w_tick_inc = r_tick + 16'd1;

    // State registers advance once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wvbd_pkg::PH_IDLE;
            r_prev_level <= 1'b1;
            r_tick       <= '0;
            r_count      <= '0;
            r_detect     <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_prev_level <= i_pin_level;
            r_tick       <= n_tick;
            r_count      <= n_count;
            r_detect     <= n_detect;
        end
    end

    // Next state: count edges in the window, compare at close, then hold.
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_count     = r_count;
        n_detect    = r_detect;
        w_strobe    = 1'b0;
        w_count_x2  = '0;
        w_thresh_x3 = {2'b00, i_cfg.threshold} + {1'b0, i_cfg.threshold, 1'b0};
        case (r_phase)
            wvbd_pkg::PH_COUNT: begin
                if (w_edge && (r_count != wvbd_pkg::COUNT_MAX)) begin
                    n_count = r_count + 8'd1;
                end
                n_tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.window_ticks) begin
                    w_strobe   = 1'b1;
                    w_count_x2 = {1'b0, n_count, 1'b0};
                    n_detect   = (w_count_x2 >= w_thresh_x3);
                    n_phase    = wvbd_pkg::PH_HOLD;
                    n_tick     = '0;
                end
            end
            wvbd_pkg::PH_HOLD: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.hold_ticks) begin
                    n_detect = 1'b0;
                    n_phase  = wvbd_pkg::PH_IDLE;
                    n_tick   = '0;
                end
            end
            default: begin
                n_phase = wvbd_pkg::PH_IDLE;
                if (w_edge) begin
                    n_phase = wvbd_pkg::PH_COUNT;
                    n_count = 8'd1;
                    n_tick  = '0;
                end
            end
        endcase
    end

    // Result word shows the state after this sample.
    assign o_result.detected      = n_detect;
    assign o_result.window_closed = w_strobe;
    assign o_result.burst_count   = n_count;
    assign o_result.busy_res      = (n_phase != wvbd_pkg::PH_IDLE);

endmodule

// ----- src/wvbd_oreg.sv -----
// ----------------------------------------------------------------------------
// wvbd_oreg
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wvbd_oreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  wvbd_pkg::t_result   i_result,
    input  logic                i_taken,
    output logic                o_valid,
    output wvbd_pkg::t_result   o_result
);

    logic              r_valid;
    wvbd_pkg::t_result r_result;

    // Valid flag: set on load, cleared when taken with nothing new behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/windowed_vibration_burst_detector.sv -----
// ----------------------------------------------------------------------------
// windowed_vibration_burst_detector
// Timing: a result word is registered and on the output in the cycle after its sample is taken.
// Throughput: one sample per cycle while the sink takes results; the output register refills as it drains.
// Reset: synchronous active low; idle, pin taken as high, registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module windowed_vibration_burst_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wvbd_in_if.sink                      i_in,
    wvbd_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wvbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [wvbd_pkg::DATA_W-1:0]  pwdata,
    output logic [wvbd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    wvbd_pkg::t_cfg    w_cfg;
    wvbd_pkg::t_result w_next_result;
    wvbd_pkg::t_result w_out_result;
    logic              w_out_valid;
    logic              w_accept;
    logic              w_taken;

    // Handshakes: a sample is taken whenever the output slot is free or draining.
    assign w_taken    = w_out_valid & o_out.ready;
    assign i_in.ready = ~w_out_valid | o_out.ready;
    assign w_accept   = i_in.valid & i_in.ready;

    // Configuration registers.
    wvbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Detector state and next-result logic.
    wvbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_pin_level (i_in.pin_level),
        .i_cfg       (w_cfg),
        .o_result    (w_next_result)
    );

    // Result register.
    wvbd_oreg u_oreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_next_result),
        .i_taken  (w_taken),
        .o_valid  (w_out_valid),
        .o_result (w_out_result)
    );

    // Output channel.
    assign o_out.valid         = w_out_valid;
    assign o_out.detected      = w_out_result.detected;
    assign o_out.window_closed = w_out_result.window_closed;
    assign o_out.burst_count   = w_out_result.burst_count;
    assign o_out.busy_res      = w_out_result.busy_res;

    // Checks.
    `WVBD_ASSERT(a_no_overwrite, (i_in.valid && i_in.ready) |-> (!o_out.valid || o_out.ready), "sample accepted over an untaken result")
    `WVBD_ASSERT(a_close_busy, (o_out.valid && o_out.window_closed) |-> o_out.busy_res, "window closed while reported idle")
    `WVBD_ASSERT(a_detect_busy, (o_out.valid && o_out.detected) |-> o_out.busy_res, "detect reported while idle")
    `WVBD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out.valid, "output valid after reset")

endmodule

// ----- sim/windowed_vibration_burst_detector_tb.sv -----
// ----------------------------------------------------------------------------
// windowed_vibration_burst_detector_tb
// Self-checking bench for the vibration burst detector. A directed table walks
// the reset state, zero-length windows and holds, zero and full thresholds,
// register masking and an unused register address. Random phases then follow,
// each with a fresh register setting and a pin pattern. Every result word is
// compared field by field with a per-sample predictor, and both channels
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_vibration_burst_detector_tb;

    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;

    // Register index with no register behind it; writes there are dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_WRITE,
        ROW_READ
    } t_row_kind;

    typedef enum logic [1:0] {
        PAT_TOGGLE,
        PAT_NOISE,
        PAT_RARE
    } t_pattern;

    typedef struct {
        t_row_kind          kind;
        logic [1:0]         reg_idx;
        logic [31:0]        data;
        logic               pin;
        bit                 typed;
        wvbd_pkg::t_result  want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [wvbd_pkg::ADDR_W-1:0] paddr;
    logic [wvbd_pkg::DATA_W-1:0] pwdata;
    logic [wvbd_pkg::DATA_W-1:0] prdata;
    logic pready;

    wvbd_in_if  sample_ch ();
    wvbd_out_if result_ch ();

    windowed_vibration_burst_detector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a copy of the registers and of the detector.
    wvbd_pkg::t_cfg    cfg_shadow;
    logic              last_pin;
    wvbd_pkg::t_phase  det_phase;
    logic [15:0]       tick_cnt;
    logic [7:0]        edge_cnt;
    logic              det_flag;

    wvbd_pkg::t_result pending_results[$];
    t_row              directed_rows[$];
    int unsigned       err_count;
    int unsigned       cycle_count;
    bit                no_idle;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // One tick of the detector, from one accepted pin sample.
    function automatic wvbd_pkg::t_result burst_step(input logic pin);
        logic              fell;
        wvbd_pkg::t_result res;
        fell = last_pin && !pin;
        last_pin = pin;
        res.window_closed = 1'b0;
        case (det_phase)
            wvbd_pkg::PH_COUNT: begin
                if (fell && edge_cnt != wvbd_pkg::COUNT_MAX) edge_cnt = edge_cnt + 8'd1;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= cfg_shadow.window_ticks) begin
                    res.window_closed = 1'b1;
                    det_flag = (2 * int'(edge_cnt) >= 3 * int'(cfg_shadow.threshold));
                    det_phase = wvbd_pkg::PH_HOLD;
                    tick_cnt = 16'd0;
                end
            end
            wvbd_pkg::PH_HOLD: begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= cfg_shadow.hold_ticks) begin
                    det_flag = 1'b0;
                    det_phase = wvbd_pkg::PH_IDLE;
                    tick_cnt = 16'd0;
                end
            end
            default: begin
                // The unused phase code behaves as idle.
                det_phase = wvbd_pkg::PH_IDLE;
                if (fell) begin
                    det_phase = wvbd_pkg::PH_COUNT;
                    edge_cnt = 8'd1;
                    tick_cnt = 16'd0;
                end
            end
        endcase
        res.detected    = det_flag;
        res.burst_count = edge_cnt;
        res.busy_res    = (det_phase != wvbd_pkg::PH_IDLE);
        return res;
    endfunction

    // Register value as read back, zero-extended to the bus width.
    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            wvbd_pkg::REG_THRESHOLD: return {24'd0, cfg_shadow.threshold};
            wvbd_pkg::REG_WINDOW:    return {16'd0, cfg_shadow.window_ticks};
            wvbd_pkg::REG_HOLD:      return {16'd0, cfg_shadow.hold_ticks};
            default:                 return 32'd0;
        endcase
    endfunction

    function automatic t_row row_pin(input logic pin);
        t_row r;
        r = '{kind: ROW_SAMPLE, reg_idx: wvbd_pkg::REG_THRESHOLD, data: 32'd0, pin: pin,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_row row_pin_want(input logic pin, input wvbd_pkg::t_result want);
        t_row r;
        r = row_pin(pin);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_row row_access(input t_row_kind kind, input logic [1:0] idx,
                                        input logic [31:0] data);
        t_row r;
        r = row_pin(1'b1);
        r.kind = kind;
        r.reg_idx = idx;
        r.data = data;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        err_count++;
    endtask

    // Send one pin sample, with random gaps, and predict its result word.
    task automatic send_sample(input logic pin, input bit typed,
                               input wvbd_pkg::t_result want);
        wvbd_pkg::t_result res;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.pin_level <= pin;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        res = burst_step(pin);
        pending_results.push_back(typed ? want : res);
    endtask

    // Stop the sample stream and let every pending word drain out.
    task automatic drain_results();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit is_write, input logic [1:0] idx,
                              input logic [31:0] data);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= wvbd_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (is_write) begin
            // Values are masked to the register width; unused indexes drop.
            case (idx)
                wvbd_pkg::REG_THRESHOLD: cfg_shadow.threshold    = data[7:0];
                wvbd_pkg::REG_WINDOW:    cfg_shadow.window_ticks = data[15:0];
                wvbd_pkg::REG_HOLD:      cfg_shadow.hold_ticks   = data[15:0];
                default: ;
            endcase
        end else if (idx != REG_UNUSED && prdata !== reg_value(idx)) begin
            flag_mismatch($sformatf("register %0d", idx), int'(prdata),
                          int'(reg_value(idx)));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        wvbd_pkg::t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result word, pending", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (result_ch.detected !== want.detected)
                    flag_mismatch("detected", result_ch.detected, want.detected);
                if (result_ch.window_closed !== want.window_closed)
                    flag_mismatch("window_closed", result_ch.window_closed,
                                  want.window_closed);
                if (result_ch.burst_count !== want.burst_count)
                    flag_mismatch("burst_count", result_ch.burst_count,
                                  want.burst_count);
                if (result_ch.busy_res !== want.busy_res)
                    flag_mismatch("busy_res", result_ch.busy_res, want.busy_res);
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** windowed_vibration_burst_detector: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned sent;
        int unsigned phase_idx;
        int unsigned phase_len;
        int unsigned run_left;
        logic [15:0] win_val;
        logic [15:0] hold_val;
        logic [7:0]  thr_val;
        logic        pin;
        bit          saturate;
        t_pattern    pattern;

        // Known values on every input before reset.
        i_rst_n             = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.pin_level = 1'b1;
        result_ch.ready     = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        err_count           = 0;
        cycle_count         = 0;
        no_idle             = 1'b0;

        cfg_shadow.threshold    = wvbd_pkg::THRESHOLD_RST;
        cfg_shadow.window_ticks = wvbd_pkg::WINDOW_RST;
        cfg_shadow.hold_ticks   = wvbd_pkg::HOLD_RST;
        last_pin  = 1'b1;
        det_phase = wvbd_pkg::PH_IDLE;
        tick_cnt  = 16'd0;
        edge_cnt  = 8'd0;
        det_flag  = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Reset values first, then a window that opens under
        // the default setting and is cut short by a zero window length.
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_THRESHOLD, 32'd0));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_WINDOW, 32'd0));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_HOLD, 32'd0));
        directed_rows.push_back(row_pin_want(1'b1, '{1'b0, 1'b0, 8'd0, 1'b0}));
        directed_rows.push_back(row_pin_want(1'b0, '{1'b0, 1'b0, 8'd1, 1'b1}));
        directed_rows.push_back(row_pin(1'b1));
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_WINDOW, 32'd0));
        directed_rows.push_back(row_pin(1'b0));
        // A zero hold length releases on the next tick.
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_HOLD, 32'd0));
        directed_rows.push_back(row_pin_want(1'b0, '{1'b0, 1'b0, 8'd2, 1'b0}));
        // Zero threshold detects every window; upper data bits are masked.
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_THRESHOLD,
                                           32'hFFFF_FF00));
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_WINDOW,
                                           32'hABCD_0001));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_THRESHOLD, 32'd0));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_WINDOW, 32'd0));
        directed_rows.push_back(row_pin_want(1'b1, '{1'b0, 1'b0, 8'd2, 1'b0}));
        directed_rows.push_back(row_pin_want(1'b0, '{1'b0, 1'b0, 8'd1, 1'b1}));
        directed_rows.push_back(row_pin_want(1'b1, '{1'b1, 1'b1, 8'd1, 1'b1}));
        directed_rows.push_back(row_pin_want(1'b0, '{1'b0, 1'b0, 8'd1, 1'b0}));
        // Full threshold never detects; a write to the unused address is dropped.
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_THRESHOLD,
                                           32'hFFFF_FFFF));
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_WINDOW, 32'd3));
        directed_rows.push_back(row_access(ROW_WRITE, wvbd_pkg::REG_HOLD, 32'd2));
        directed_rows.push_back(row_access(ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_THRESHOLD, 32'd0));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_WINDOW, 32'd0));
        directed_rows.push_back(row_access(ROW_READ, wvbd_pkg::REG_HOLD, 32'd0));
        directed_rows.push_back(row_pin(1'b1));
        directed_rows.push_back(row_pin(1'b0));
        directed_rows.push_back(row_pin(1'b1));
        directed_rows.push_back(row_pin(1'b0));
        directed_rows.push_back(row_pin_want(1'b1, '{1'b0, 1'b1, 8'd2, 1'b1}));
        directed_rows.push_back(row_pin_want(1'b0, '{1'b0, 1'b0, 8'd2, 1'b1}));
        directed_rows.push_back(row_pin_want(1'b0, '{1'b0, 1'b0, 8'd2, 1'b0}));

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WRITE: apb_access(1'b1, directed_rows[i].reg_idx, directed_rows[i].data);
                ROW_READ:  apb_access(1'b0, directed_rows[i].reg_idx, 32'd0);
                default:   send_sample(directed_rows[i].pin, directed_rows[i].typed,
                                       directed_rows[i].want);
            endcase
        end

        // Random phases: a fresh setting, then a run of pin samples.
        sent = 0;
        phase_idx = 0;
        pin = 1'b1;
        run_left = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       thr_val = 8'd0;
                1:       thr_val = 8'd255;
                2:       thr_val = 8'd1;
                default: thr_val = 8'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       win_val = 16'd0;
                1:       win_val = 16'd1;
                2:       win_val = 16'd65535;
                default: win_val = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 9))
                0:       hold_val = 16'd0;
                1:       hold_val = 16'd1;
                2:       hold_val = 16'd65535;
                default: hold_val = 16'($urandom_range(1, 30));
            endcase
            phase_len = $urandom_range(40, 140);
            saturate = (phase_idx == 1);
            // One long window of strict toggling drives the count to saturation.
            if (saturate) begin
                thr_val   = 8'd100;
                win_val   = 16'd560;
                hold_val  = 16'd5;
                phase_len = 600;
            end
            no_idle = (phase_idx == 3);

            apb_access(1'b1, wvbd_pkg::REG_THRESHOLD,
                       ($urandom() & 32'hFFFF_FF00) | 32'(thr_val));
            apb_access(1'b1, wvbd_pkg::REG_WINDOW,
                       ($urandom() & 32'hFFFF_0000) | 32'(win_val));
            apb_access(1'b1, wvbd_pkg::REG_HOLD,
                       ($urandom() & 32'hFFFF_0000) | 32'(hold_val));
            apb_access(1'b0, wvbd_pkg::REG_THRESHOLD, 32'd0);
            apb_access(1'b0, wvbd_pkg::REG_WINDOW, 32'd0);
            apb_access(1'b0, wvbd_pkg::REG_HOLD, 32'd0);

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: pattern = PAT_TOGGLE;
                5, 6, 7:       pattern = PAT_RARE;
                default:       pattern = PAT_NOISE;
            endcase
            if (saturate) pattern = PAT_TOGGLE;

            for (int unsigned k = 0; k < phase_len; k++) begin
                case (pattern)
                    PAT_TOGGLE: begin
                        if (run_left == 0) begin
                            pin = ~pin;
                            run_left = saturate ? 0 : $urandom_range(0, 2);
                        end else begin
                            run_left--;
                        end
                    end
                    PAT_RARE: pin = ($urandom_range(0, 99) < 6) ? 1'b0 : 1'b1;
                    default:  pin = 1'($urandom_range(0, 1));
                endcase
                send_sample(pin, 1'b0, '0);
                sent++;
            end
            phase_idx++;
        end
        no_idle = 1'b0;

        drain_results();

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("** windowed_vibration_burst_detector: PASSED **");
        end else begin
            $display("** windowed_vibration_burst_detector: FAILED **");
        end
        $finish;
    end

endmodule
